// ===== hdl/lrc_pkg.sv =====
package lrc_pkg;

    localparam int LRC_SLOT_COUNT  = 16;
    localparam int LRC_BLOCK_SHIFT = 22;

    localparam int TAG_W   = 42;
    localparam int LEN_W   = 23;
    localparam int STAMP_W = 32;
    localparam int OFF_W   = 64;
    localparam int WORD_W  = TAG_W + LEN_W + STAMP_W;

    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_FILL   = 1'b1;

    typedef enum logic [1:0] {
        STAT_HIT    = 2'd0,
        STAT_MISS   = 2'd1,
        STAT_FILL   = 2'd2,
        STAT_NOPEND = 2'd3
    } lrc_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } lrc_state_t;

endpackage

// ===== hdl/lrc_slot_mem.sv =====
module lrc_slot_mem #(
    parameter int DEPTH  = lrc_pkg::LRC_SLOT_COUNT,
    parameter int WIDTH  = lrc_pkg::WORD_W,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/lrc_len_clip.sv =====
module lrc_len_clip #(
    parameter int BLOCK_SHIFT = lrc_pkg::LRC_BLOCK_SHIFT
) (
    input  logic [lrc_pkg::OFF_W-1:0] offset,
    input  logic [lrc_pkg::OFF_W-1:0] total,
    output logic [lrc_pkg::LEN_W-1:0] length
);

    import lrc_pkg::*;

    localparam logic [OFF_W-1:0] BLOCK_BYTES = OFF_W'(1) << BLOCK_SHIFT;

    logic [OFF_W:0]   diff;
    logic [OFF_W-1:0] rem;

    assign diff = {1'b0, total} - {1'b0, offset};
    assign rem  = diff[OFF_W-1:0];

    always_comb
    begin
        if (diff[OFF_W])
        begin
            length = '0;
        end
        else if (rem[OFF_W-1:BLOCK_SHIFT] == '0)
        begin
            length = rem[LEN_W-1:0];
        end
        else
        begin
            length = BLOCK_BYTES[LEN_W-1:0];
        end
    end

endmodule

// ===== hdl/source_block_lru_cache_core.sv =====
// Channel  Signals                                         Dir  Transaction when
// in       in_valid, in_stall, req_type, block_number,     in   in_valid && !in_stall
//          fill_length
// out      out_valid, out_stall, status, slot_index,       out  out_valid && !out_stall
//          hit_length, request_offset, request_length
// cfg      cfg_valid, cfg_ready, cfg_data                  in   cfg_valid && cfg_ready
//
// A lookup reads the slot memory one entry per cycle: a miss registers its result after
// the last slot is read, a hit in slot k once slot k is read; the next transaction can
// follow once that result has moved on. A fill result is registered without a scan. The
// single read port of the slot memory sets this pace of the scan.
// Reset clears valid bits, pending flag, use counter and source size; no clearing pass.
// A new item is taken while a result waits on out_stall; it completes once out is free.
module source_block_lru_cache_core #(
    parameter int SLOT_COUNT  = lrc_pkg::LRC_SLOT_COUNT,
    parameter int BLOCK_SHIFT = lrc_pkg::LRC_BLOCK_SHIFT,
    parameter int IDX_W       = $clog2(SLOT_COUNT)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [lrc_pkg::OFF_W-1:0]   cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        req_type,
    input  logic [lrc_pkg::TAG_W-1:0]   block_number,
    input  logic [lrc_pkg::LEN_W-1:0]   fill_length,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  status,
    output logic [IDX_W-1:0]            slot_index,
    output logic [lrc_pkg::LEN_W-1:0]   hit_length,
    output logic [lrc_pkg::OFF_W-1:0]   request_offset,
    output logic [lrc_pkg::LEN_W-1:0]   request_length
);

    import lrc_pkg::*;

    localparam int CNT_W = $clog2(SLOT_COUNT + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);
    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(SLOT_COUNT);

    lrc_state_t state_reg, state_next;

    logic [OFF_W-1:0]      total_reg;
    logic [SLOT_COUNT-1:0] valid_reg, valid_next;
    logic [STAMP_W-1:0]    use_cnt_reg, use_cnt_next;
    logic                  pend_vld_reg, pend_vld_next;
    logic [IDX_W-1:0]      pend_slot_reg, pend_slot_next;
    logic [TAG_W-1:0]      pend_tag_reg, pend_tag_next;

    logic                  type_reg;
    logic [TAG_W-1:0]      blk_reg;
    logic [LEN_W-1:0]      flen_reg;

    logic [CNT_W-1:0]      issue_reg, issue_next;
    logic                  rd_vld_reg;
    logic [IDX_W-1:0]      rd_idx_reg;
    logic [IDX_W-1:0]      best_idx_reg, best_idx_next;
    logic [STAMP_W-1:0]    best_stamp_reg, best_stamp_next;
    logic                  best_ok_reg, best_ok_next;

    lrc_status_t           res_stat_reg, res_stat_next;
    logic [IDX_W-1:0]      res_slot_reg, res_slot_next;
    logic [LEN_W-1:0]      res_len_reg, res_len_next;

    logic                  out_vld_reg, out_vld_next;
    lrc_status_t           out_stat_reg, out_stat_next;
    logic [IDX_W-1:0]      out_slot_reg, out_slot_next;
    logic [LEN_W-1:0]      out_hlen_reg, out_hlen_next;
    logic [OFF_W-1:0]      out_off_reg, out_off_next;
    logic [LEN_W-1:0]      out_rlen_reg, out_rlen_next;

    logic                  in_take;
    logic                  out_free;
    logic                  issue;
    logic                  hit_now;
    logic                  last_now;
    logic                  cand_better;
    logic                  any_inv;
    logic [IDX_W-1:0]      first_inv;
    logic [OFF_W-1:0]      req_off;
    logic [LEN_W-1:0]      clip_len;

    logic                  mem_wr_en;
    logic [IDX_W-1:0]      mem_wr_addr;
    logic [WORD_W-1:0]     mem_wr_data;
    logic [WORD_W-1:0]     mem_rd_data;
    logic [TAG_W-1:0]      rd_tag;
    logic [LEN_W-1:0]      rd_len;
    logic [STAMP_W-1:0]    rd_stamp;

    lrc_slot_mem #(
        .DEPTH  (SLOT_COUNT),
        .WIDTH  (WORD_W),
        .ADDR_W (IDX_W)
    ) u_slot_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (issue),
        .rd_addr (issue_reg[IDX_W-1:0]),
        .rd_data (mem_rd_data)
    );

    lrc_len_clip #(
        .BLOCK_SHIFT (BLOCK_SHIFT)
    ) u_len_clip (
        .offset (req_off),
        .total  (total_reg),
        .length (clip_len)
    );

    assign rd_tag   = mem_rd_data[WORD_W-1 -: TAG_W];
    assign rd_len   = mem_rd_data[STAMP_W +: LEN_W];
    assign rd_stamp = mem_rd_data[STAMP_W-1:0];

    assign req_off  = OFF_W'(blk_reg) << BLOCK_SHIFT;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_free  = !out_vld_reg || !out_stall;

    assign issue       = (state_reg == S_SCAN) && (issue_reg != CNT_END);
    assign hit_now     = (state_reg == S_SCAN) && rd_vld_reg && valid_reg[rd_idx_reg]
                         && (rd_tag == blk_reg);
    assign last_now    = (state_reg == S_SCAN) && rd_vld_reg && (rd_idx_reg == LAST_IDX);
    assign cand_better = !best_ok_reg || (rd_stamp < best_stamp_reg);

    always_comb
    begin
        any_inv   = 1'b0;
        first_inv = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                any_inv   = 1'b1;
                first_inv = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    state_next = (req_type == REQ_FILL) ? S_DONE : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (hit_now || last_now)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        valid_next      = valid_reg;
        use_cnt_next    = use_cnt_reg;
        pend_vld_next   = pend_vld_reg;
        pend_slot_next  = pend_slot_reg;
        pend_tag_next   = pend_tag_reg;
        issue_next      = issue_reg;
        best_idx_next   = best_idx_reg;
        best_stamp_next = best_stamp_reg;
        best_ok_next    = best_ok_reg;
        res_stat_next   = res_stat_reg;
        res_slot_next   = res_slot_reg;
        res_len_next    = res_len_reg;
        out_vld_next    = out_vld_reg;
        out_stat_next   = out_stat_reg;
        out_slot_next   = out_slot_reg;
        out_hlen_next   = out_hlen_reg;
        out_off_next    = out_off_reg;
        out_rlen_next   = out_rlen_reg;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = pend_slot_reg;
        mem_wr_data     = {pend_tag_reg, flen_reg, use_cnt_reg + STAMP_W'(1)};

        if (out_vld_reg && !out_stall)
        begin
            out_vld_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                issue_next   = '0;
                best_ok_next = 1'b0;
                res_stat_next = pend_vld_reg ? STAT_FILL : STAT_NOPEND;
            end
            S_SCAN:
            begin
                if (issue)
                begin
                    issue_next = issue_reg + CNT_W'(1);
                end
                if (rd_vld_reg && cand_better)
                begin
                    best_idx_next   = rd_idx_reg;
                    best_stamp_next = rd_stamp;
                    best_ok_next    = 1'b1;
                end
                if (hit_now)
                begin
                    res_stat_next = STAT_HIT;
                    res_slot_next = rd_idx_reg;
                    res_len_next  = rd_len;
                end
                else if (last_now)
                begin
                    res_stat_next = STAT_MISS;
                    if (any_inv)
                    begin
                        res_slot_next = first_inv;
                    end
                    else if (cand_better)
                    begin
                        res_slot_next = rd_idx_reg;
                    end
                    else
                    begin
                        res_slot_next = best_idx_reg;
                    end
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_vld_next  = 1'b1;
                    out_stat_next = res_stat_reg;
                    out_slot_next = '0;
                    out_hlen_next = '0;
                    out_off_next  = '0;
                    out_rlen_next = '0;
                    case (res_stat_reg)
                        STAT_HIT:
                        begin
                            use_cnt_next  = use_cnt_reg + STAMP_W'(1);
                            mem_wr_en     = 1'b1;
                            mem_wr_addr   = res_slot_reg;
                            mem_wr_data   = {blk_reg, res_len_reg, use_cnt_next};
                            out_slot_next = res_slot_reg;
                            out_hlen_next = res_len_reg;
                        end
                        STAT_MISS:
                        begin
                            pend_vld_next  = 1'b1;
                            pend_slot_next = res_slot_reg;
                            pend_tag_next  = blk_reg;
                            out_slot_next  = res_slot_reg;
                            out_off_next   = req_off;
                            out_rlen_next  = clip_len;
                        end
                        STAT_FILL:
                        begin
                            use_cnt_next  = use_cnt_reg + STAMP_W'(1);
                            mem_wr_en     = 1'b1;
                            mem_wr_addr   = pend_slot_reg;
                            mem_wr_data   = {pend_tag_reg, flen_reg, use_cnt_next};
                            valid_next[pend_slot_reg] = 1'b1;
                            pend_vld_next = 1'b0;
                            out_slot_next = pend_slot_reg;
                            out_hlen_next = flen_reg;
                        end
                        default:
                        begin
                            out_stat_next = STAT_NOPEND;
                        end
                    endcase
                end
            end
            default:
            begin
                issue_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            total_reg    <= '0;
            valid_reg    <= '0;
            use_cnt_reg  <= '0;
            pend_vld_reg <= 1'b0;
            rd_vld_reg   <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            use_cnt_reg  <= use_cnt_next;
            pend_vld_reg <= pend_vld_next;
            rd_vld_reg   <= issue;
            out_vld_reg  <= out_vld_next;
            if (cfg_valid && cfg_ready)
            begin
                total_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            type_reg <= req_type;
            blk_reg  <= block_number;
            flen_reg <= fill_length;
        end
        pend_slot_reg  <= pend_slot_next;
        pend_tag_reg   <= pend_tag_next;
        issue_reg      <= issue_next;
        rd_idx_reg     <= issue_reg[IDX_W-1:0];
        best_idx_reg   <= best_idx_next;
        best_stamp_reg <= best_stamp_next;
        best_ok_reg    <= best_ok_next;
        res_stat_reg   <= (in_take && type_reg == REQ_LOOKUP && req_type == REQ_LOOKUP)
                          ? STAT_MISS : res_stat_next;
        res_slot_reg   <= res_slot_next;
        res_len_reg    <= res_len_next;
        out_stat_reg   <= out_stat_next;
        out_slot_reg   <= out_slot_next;
        out_hlen_reg   <= out_hlen_next;
        out_off_reg    <= out_off_next;
        out_rlen_reg   <= out_rlen_next;
    end

    assign out_valid      = out_vld_reg;
    assign status         = out_stat_reg;
    assign slot_index     = out_slot_reg;
    assign hit_length     = out_hlen_reg;
    assign request_offset = out_off_reg;
    assign request_length = out_rlen_reg;

endmodule

// ===== bench/lrc_tb_pkg.sv =====
`timescale 1ns / 100ps

package lrc_tb_pkg;

    import lrc_pkg::*;

    typedef struct {
        lrc_status_t        status;
        logic [3:0]         slot;
        logic [LEN_W-1:0]   hit_len;
        logic [OFF_W-1:0]   offset;
        logic [LEN_W-1:0]   req_len;
    } cache_outcome_t;

    class cache_tag_scoreboard;

        logic               slot_live  [LRC_SLOT_COUNT];
        logic [TAG_W-1:0]   slot_tag   [LRC_SLOT_COUNT];
        logic [LEN_W-1:0]   slot_len   [LRC_SLOT_COUNT];
        logic [STAMP_W-1:0] slot_stamp [LRC_SLOT_COUNT];
        logic [STAMP_W-1:0] use_count;
        logic               fill_waiting;
        logic [3:0]         fill_slot;
        logic [TAG_W-1:0]   fill_tag;
        logic [OFF_W-1:0]   source_bytes;
        cache_outcome_t     expected_outcomes[$];
        int                 errors;

        function new();
            for (int i = 0; i < LRC_SLOT_COUNT; i++)
            begin
                slot_live[i]  = 1'b0;
                slot_tag[i]   = '0;
                slot_len[i]   = '0;
                slot_stamp[i] = '0;
            end
            use_count    = '0;
            fill_waiting = 1'b0;
            fill_slot    = '0;
            fill_tag     = '0;
            source_bytes = '0;
            errors       = 0;
        endfunction

        task report(input string what);
            $display("[%0t] mismatch: %s", $time, what);
            errors++;
        endtask

        task note_request(input logic req, input logic [TAG_W-1:0] blk,
                          input logic [LEN_W-1:0] flen);
            cache_outcome_t   r;
            bit               hit;
            int               victim;
            int               best;
            logic [OFF_W-1:0] rem;
            r.status  = STAT_NOPEND;
            r.slot    = '0;
            r.hit_len = '0;
            r.offset  = '0;
            r.req_len = '0;
            if (req == REQ_LOOKUP)
            begin
                hit = 1'b0;
                for (int i = 0; i < LRC_SLOT_COUNT; i++)
                begin
                    if (!hit && slot_live[i] && slot_tag[i] == blk)
                    begin
                        use_count     = use_count + 1'b1;
                        slot_stamp[i] = use_count;
                        r.status      = STAT_HIT;
                        r.slot        = 4'(i);
                        r.hit_len     = slot_len[i];
                        hit           = 1'b1;
                    end
                end
                if (!hit)
                begin
                    victim = -1;
                    best   = 0;
                    for (int i = 0; i < LRC_SLOT_COUNT; i++)
                    begin
                        if (victim < 0 && !slot_live[i])
                            victim = i;
                        if (slot_stamp[i] < slot_stamp[best])
                            best = i;
                    end
                    if (victim < 0)
                        victim = best;
                    fill_waiting = 1'b1;
                    fill_slot    = 4'(victim);
                    fill_tag     = blk;
                    r.status     = STAT_MISS;
                    r.slot       = 4'(victim);
                    r.offset     = OFF_W'(blk) << LRC_BLOCK_SHIFT;
                    if (r.offset < source_bytes)
                    begin
                        rem = source_bytes - r.offset;
                        if (rem < (64'd1 << LRC_BLOCK_SHIFT))
                            r.req_len = rem[LEN_W-1:0];
                        else
                            r.req_len = LEN_W'(64'd1 << LRC_BLOCK_SHIFT);
                    end
                end
            end
            else if (fill_waiting)
            begin
                slot_live[fill_slot]  = 1'b1;
                slot_tag[fill_slot]   = fill_tag;
                slot_len[fill_slot]   = flen;
                use_count             = use_count + 1'b1;
                slot_stamp[fill_slot] = use_count;
                fill_waiting          = 1'b0;
                r.status              = STAT_FILL;
                r.slot                = fill_slot;
                r.hit_len             = flen;
            end
            expected_outcomes.push_back(r);
        endtask

        task check_outcome(input logic [1:0] st, input logic [3:0] slot,
                           input logic [LEN_W-1:0] hit_len, input logic [OFF_W-1:0] offset,
                           input logic [LEN_W-1:0] req_len);
            cache_outcome_t e;
            if (expected_outcomes.size() == 0)
            begin
                report($sformatf("result status %0d with no transaction outstanding", st));
                return;
            end
            e = expected_outcomes.pop_front();
            if (st !== e.status)
                report($sformatf("status got %0d exp %0d", st, e.status));
            if (slot !== e.slot)
                report($sformatf("slot_index got %0d exp %0d", slot, e.slot));
            if (hit_len !== e.hit_len)
                report($sformatf("hit_length got %0d exp %0d", hit_len, e.hit_len));
            if (offset !== e.offset)
                report($sformatf("request_offset got %0h exp %0h", offset, e.offset));
            if (req_len !== e.req_len)
                report($sformatf("request_length got %0d exp %0d", req_len, e.req_len));
        endtask

    endclass

endpackage

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    import lrc_pkg::*;
    import lrc_tb_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int LEN_FULL    = 1 << LRC_BLOCK_SHIFT;
    localparam int POOL_SIZE   = 20;
    localparam int PHASE_ITEMS = 120;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               cfg_valid    = 1'b0;
    logic               cfg_ready;
    logic [OFF_W-1:0]   cfg_data     = '0;
    logic               in_valid     = 1'b0;
    logic               in_stall;
    logic               req_type     = REQ_LOOKUP;
    logic [TAG_W-1:0]   block_number = '0;
    logic [LEN_W-1:0]   fill_length  = '0;
    logic               out_valid;
    logic               out_stall    = 1'b0;
    logic [1:0]         status;
    logic [3:0]         slot_index;
    logic [LEN_W-1:0]   hit_length;
    logic [OFF_W-1:0]   request_offset;
    logic [LEN_W-1:0]   request_length;

    cache_tag_scoreboard sb = new();

    int                 burst_left   = 0;
    int                 gap_max      = 4;
    int                 stall_left   = 0;
    int                 stall_mode   = 0;
    int                 quiet_cycles = 0;
    logic [TAG_W-1:0]   tag_pool [POOL_SIZE];
    logic [OFF_W-1:0]   totals   [7];

    source_block_lru_cache_core i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .req_type       (req_type),
        .block_number   (block_number),
        .fill_length    (fill_length),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .slot_index     (slot_index),
        .hit_length     (hit_length),
        .request_offset (request_offset),
        .request_length (request_length)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_outcome(status, slot_index, hit_length, request_offset, request_length);
        if (stall_left == 0)
        begin
            if ($urandom_range(0, 7) == 0)
                stall_mode = $urandom_range(0, 2);
            case (stall_mode)
                0:
                begin
                    out_stall  <= 1'b0;
                    stall_left = $urandom_range(8, 40);
                end
                1:
                begin
                    out_stall  <= ($urandom_range(0, 2) == 0);
                    stall_left = 0;
                end
                default:
                begin
                    out_stall  <= ~out_stall;
                    stall_left = $urandom_range(1, 25);
                end
            endcase
        end
        else
            stall_left--;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[source_block_lru_cache_core] ERROR");
            $finish;
        end
    end

    task automatic wait_drained();
        while (sb.expected_outcomes.size() != 0)
            @(posedge clk);
        repeat (LRC_SLOT_COUNT + 4) @(posedge clk);
    endtask

    task automatic write_total(input logic [OFF_W-1:0] value);
        in_valid <= 1'b0;
        burst_left = 0;
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.source_bytes = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic send_item(input logic req, input logic [TAG_W-1:0] blk,
                             input logic [LEN_W-1:0] flen);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid     <= 1'b1;
        req_type     <= req;
        block_number <= blk;
        fill_length  <= flen;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_request(req, blk, flen);
    endtask

    task automatic random_item();
        int               r;
        logic             req;
        logic [TAG_W-1:0] blk;
        logic [LEN_W-1:0] flen;
        r = $urandom_range(0, 99);
        if (sb.fill_waiting)
            req = (r < 80) ? REQ_FILL : REQ_LOOKUP;
        else
            req = (r < 8) ? REQ_FILL : REQ_LOOKUP;
        if ($urandom_range(0, 99) < 80)
            blk = tag_pool[$urandom_range(0, POOL_SIZE - 1)];
        else
            blk = TAG_W'({$urandom, $urandom});
        if ($urandom_range(0, 19) == 0)
            flen = LEN_W'(LEN_FULL);
        else
            flen = LEN_W'($urandom_range(0, LEN_FULL));
        send_item(req, blk, flen);
    endtask

    initial
    begin
        totals[0] = '1;
        totals[1] = '0;
        totals[2] = (64'd5 << LRC_BLOCK_SHIFT) + 64'd123;
        totals[3] = 64'd1;
        totals[4] = (64'd16 << LRC_BLOCK_SHIFT) - 64'd1;
        totals[5] = {$urandom, $urandom};
        totals[6] = 64'd12 << LRC_BLOCK_SHIFT;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_total((64'd3 << LRC_BLOCK_SHIFT) + 64'd100);
        send_item(REQ_FILL,   '1,          LEN_W'(LEN_FULL));
        send_item(REQ_LOOKUP, TAG_W'(0),   LEN_W'(LEN_FULL));
        send_item(REQ_FILL,   TAG_W'(0),   LEN_W'(LEN_FULL));
        send_item(REQ_LOOKUP, TAG_W'(0),   '0);
        send_item(REQ_LOOKUP, TAG_W'(3),   '0);
        send_item(REQ_LOOKUP, TAG_W'(5),   '0);
        send_item(REQ_LOOKUP, TAG_W'(0),   '1);
        send_item(REQ_FILL,   TAG_W'(0),   '0);
        send_item(REQ_LOOKUP, TAG_W'(5),   '0);
        send_item(REQ_LOOKUP, '1,          '0);
        send_item(REQ_FILL,   TAG_W'(0),   LEN_W'(LEN_FULL - 1));
        send_item(REQ_LOOKUP, '1,          '0);
        send_item(REQ_LOOKUP, TAG_W'(2),   '0);
        send_item(REQ_FILL,   TAG_W'(0),   LEN_W'(12345));
        send_item(REQ_FILL,   TAG_W'(0),   LEN_W'(99));
        send_item(REQ_LOOKUP, TAG_W'(1),   '0);
        send_item(REQ_LOOKUP, TAG_W'(1),   '0);
        send_item(REQ_FILL,   TAG_W'(0),   LEN_W'(7));

        for (int p = 0; p < 7; p++)
        begin
            write_total(totals[p]);
            for (int i = 0; i < POOL_SIZE; i++)
            begin
                if (i < 10)
                    tag_pool[i] = TAG_W'(i);
                else if (i < 14)
                    tag_pool[i] = {TAG_W{1'b1}} - TAG_W'(i - 10);
                else
                    tag_pool[i] = TAG_W'({$urandom, $urandom});
            end
            gap_max = (p == 2) ? 0 : $urandom_range(2, 10);
            repeat (PHASE_ITEMS) random_item();
        end

        in_valid <= 1'b0;
        wait_drained();
        if (sb.errors == 0)
            $display("[source_block_lru_cache_core] OK");
        else
            $display("[source_block_lru_cache_core] ERROR");
        $finish;
    end

endmodule
